// File: rtl/es2cd_pkg.sv
// shared types, constants and helpers for the epoch-to-date converter
`default_nettype none

package es2cd_pkg;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DAY_QUO,
        OP_DAY_REM,
        OP_HOUR_QUO,
        OP_HOUR_REM,
        OP_MIN_QUO,
        OP_MIN_REM,
        OP_WDAY_QUO,
        OP_WDAY_REM,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } status_t;

    localparam int unsigned TIME_W  = 31;
    localparam int unsigned DAYS_W  = 15;
    localparam int unsigned YEAR_W  = 11;

    // shared multiplier operand and product widths
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned PROD_W  = 49;

    // reciprocals, rounded up, exact over each operand's range
    // days    = ((t >> 7) * DAY_RECIP) >> 34       (86400 = 128 * 675)
    // hours   = ((sod >> 4) * HOUR_RECIP) >> 21    (3600 = 16 * 225)
    // minutes = ((r >> 2) * MIN_RECIP) >> 14       (60 = 4 * 15)
    // weeks   = (n * WEEK_RECIP) >> 18
    localparam logic [MUL_A_W-1:0] DAY_RECIP  = MUL_A_W'(25451659);
    localparam logic [MUL_A_W-1:0] HOUR_RECIP = MUL_A_W'(9321);
    localparam logic [MUL_A_W-1:0] MIN_RECIP  = MUL_A_W'(1093);
    localparam logic [MUL_A_W-1:0] WEEK_RECIP = MUL_A_W'(37450);

    // divisors, multiplied back to form the remainders
    localparam logic [MUL_B_W-1:0] SECS_PER_DAY  = MUL_B_W'(86400);
    localparam logic [MUL_B_W-1:0] SECS_PER_HOUR = MUL_B_W'(3600);
    localparam logic [MUL_B_W-1:0] SECS_PER_MIN  = MUL_B_W'(60);
    localparam logic [MUL_B_W-1:0] DAYS_PER_WEEK = MUL_B_W'(7);

    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = YEAR_W'(1970);
    localparam logic [YEAR_W-1:0] YEAR_ONE      = YEAR_W'(1);
    localparam logic [2:0]        EPOCH_WEEKDAY = 3'd4;
    localparam logic [1:0]        EPOCH_MOD4    = 2'd2;
    localparam logic [6:0]        EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]        EPOCH_MOD400  = 9'd370;

    localparam logic [8:0] YEAR_DAYS      = 9'd365;
    localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;
    localparam logic [3:0] LAST_MONTH     = 4'd12;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/es2cd_dpath.sv
// datapath: shared reciprocal multiplier, year and month walk, result registers
`default_nettype none

module es2cd_dpath (
    input  wire                          aclk,
    input  es2cd_pkg::cmd_t              cmd,
    output es2cd_pkg::status_t           status,
    input  wire [es2cd_pkg::TIME_W-1:0]  s_epoch_seconds,
    output logic [4:0]                   m_day_of_month,
    output logic [3:0]                   m_month_number,
    output logic [es2cd_pkg::YEAR_W-1:0] m_year_number,
    output logic [2:0]                   m_weekday,
    output logic [4:0]                   m_hour_of_day,
    output logic [5:0]                   m_minute_of_hour,
    output logic [5:0]                   m_second_of_minute
);

    logic [es2cd_pkg::TIME_W-1:0] rem_reg, rem_next;
    logic [11:0]                  quo_reg, quo_next;
    logic [es2cd_pkg::DAYS_W-1:0] days_reg, days_next;
    logic [4:0]                   hour_reg, hour_next;
    logic [5:0]                   min_reg, min_next;
    logic [5:0]                   sec_reg, sec_next;
    logic [2:0]                   wday_reg, wday_next;
    logic [es2cd_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [1:0]                   mod4_reg, mod4_next;
    logic [6:0]                   mod100_reg, mod100_next;
    logic [8:0]                   mod400_reg, mod400_next;
    logic [3:0]                   month_reg, month_next;

    logic                          leap;
    logic [8:0]                    ylen;
    logic [4:0]                    mlen;
    logic [15:0]                   wd_num;
    logic [es2cd_pkg::MUL_A_W-1:0] mul_a;
    logic [es2cd_pkg::MUL_B_W-1:0] mul_b;
    logic [es2cd_pkg::PROD_W-1:0]  prod;

    assign leap = (mod400_reg == 9'd0) || ((mod100_reg != 7'd0) && (mod4_reg == 2'd0));
    assign ylen = leap ? es2cd_pkg::LEAP_YEAR_DAYS : es2cd_pkg::YEAR_DAYS;
    assign mlen = es2cd_pkg::month_len(month_reg, leap);
    assign wd_num = {1'b0, days_reg} + {13'd0, es2cd_pkg::EPOCH_WEEKDAY};

    assign status.year_fits  = (days_reg >= {6'd0, ylen});
    assign status.month_fits = (month_reg < es2cd_pkg::LAST_MONTH) &&
                               (days_reg >= {10'd0, mlen});

    // one multiplier, operands picked by the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            es2cd_pkg::OP_DAY_QUO: begin
                mul_a = es2cd_pkg::DAY_RECIP;
                mul_b = rem_reg[30:7];
            end
            es2cd_pkg::OP_DAY_REM: begin
                mul_a = {10'd0, days_reg};
                mul_b = es2cd_pkg::SECS_PER_DAY;
            end
            es2cd_pkg::OP_HOUR_QUO: begin
                mul_a = es2cd_pkg::HOUR_RECIP;
                mul_b = {11'd0, rem_reg[16:4]};
            end
            es2cd_pkg::OP_HOUR_REM: begin
                mul_a = {20'd0, hour_reg};
                mul_b = es2cd_pkg::SECS_PER_HOUR;
            end
            es2cd_pkg::OP_MIN_QUO: begin
                mul_a = es2cd_pkg::MIN_RECIP;
                mul_b = {14'd0, rem_reg[11:2]};
            end
            es2cd_pkg::OP_MIN_REM: begin
                mul_a = {19'd0, min_reg};
                mul_b = es2cd_pkg::SECS_PER_MIN;
            end
            es2cd_pkg::OP_WDAY_QUO: begin
                mul_a = es2cd_pkg::WEEK_RECIP;
                mul_b = {8'd0, wd_num};
            end
            es2cd_pkg::OP_WDAY_REM: begin
                mul_a = {13'd0, quo_reg};
                mul_b = es2cd_pkg::DAYS_PER_WEEK;
            end
            default: begin
            end
        endcase
    end

    assign prod = {24'd0, mul_a} * {25'd0, mul_b};

    always_comb begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        wday_next   = wday_reg;
        year_next   = year_reg;
        mod4_next   = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;
        case (cmd.op)
            es2cd_pkg::OP_LOAD: begin
                rem_next = s_epoch_seconds;
            end
            es2cd_pkg::OP_DAY_QUO: begin
                days_next = prod[48:34];
            end
            es2cd_pkg::OP_DAY_REM: begin
                rem_next = rem_reg - prod[es2cd_pkg::TIME_W-1:0];
            end
            es2cd_pkg::OP_HOUR_QUO: begin
                hour_next = prod[25:21];
            end
            es2cd_pkg::OP_HOUR_REM: begin
                rem_next = rem_reg - prod[es2cd_pkg::TIME_W-1:0];
            end
            es2cd_pkg::OP_MIN_QUO: begin
                min_next = prod[19:14];
            end
            es2cd_pkg::OP_MIN_REM: begin
                sec_next = rem_reg[5:0] - prod[5:0];
            end
            es2cd_pkg::OP_WDAY_QUO: begin
                quo_next = prod[29:18];
            end
            es2cd_pkg::OP_WDAY_REM: begin
                wday_next   = wd_num[2:0] - prod[2:0];
                year_next   = es2cd_pkg::EPOCH_YEAR;
                mod4_next   = es2cd_pkg::EPOCH_MOD4;
                mod100_next = es2cd_pkg::EPOCH_MOD100;
                mod400_next = es2cd_pkg::EPOCH_MOD400;
                month_next  = 4'd1;
            end
            es2cd_pkg::OP_YEAR_STEP: begin
                days_next   = days_reg - {6'd0, ylen};
                year_next   = year_reg + es2cd_pkg::YEAR_ONE;
                mod4_next   = mod4_reg + 2'd1;
                mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
            end
            es2cd_pkg::OP_MONTH_STEP: begin
                days_next  = days_reg - {10'd0, mlen};
                month_next = month_reg + 4'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        sec_reg    <= sec_next;
        wday_reg   <= wday_next;
        year_reg   <= year_next;
        mod4_reg   <= mod4_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
    end

    // result registers, held while the finished request waits downstream
    always_ff @(posedge aclk) begin
        if (cmd.op == es2cd_pkg::OP_FINISH) begin
            m_day_of_month     <= days_reg[4:0] + 5'd1;
            m_month_number     <= month_reg;
            m_year_number      <= year_reg;
            m_weekday          <= wday_reg;
            m_hour_of_day      <= hour_reg;
            m_minute_of_hour   <= min_reg;
            m_second_of_minute <= sec_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/es2cd_ctrl.sv
// controller: sequences the divisions and walks, runs both handshakes
`default_nettype none

module es2cd_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    output es2cd_pkg::cmd_t      cmd,
    input  es2cd_pkg::status_t   status
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DAY_QUO  = 4'd1;
    localparam logic [3:0] ST_DAY_REM  = 4'd2;
    localparam logic [3:0] ST_HOUR_QUO = 4'd3;
    localparam logic [3:0] ST_HOUR_REM = 4'd4;
    localparam logic [3:0] ST_MIN_QUO  = 4'd5;
    localparam logic [3:0] ST_MIN_REM  = 4'd6;
    localparam logic [3:0] ST_WDAY_QUO = 4'd7;
    localparam logic [3:0] ST_WDAY_REM = 4'd8;
    localparam logic [3:0] ST_YEAR     = 4'd9;
    localparam logic [3:0] ST_MONTH    = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    logic [3:0]                    state_reg, state_next;
    logic                          m_valid_reg, m_valid_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = es2cd_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = es2cd_pkg::OP_LOAD;
                    state_next = ST_DAY_QUO;
                end
            end
            ST_DAY_QUO: begin
                cmd.op     = es2cd_pkg::OP_DAY_QUO;
                state_next = ST_DAY_REM;
            end
            ST_DAY_REM: begin
                cmd.op     = es2cd_pkg::OP_DAY_REM;
                state_next = ST_HOUR_QUO;
            end
            ST_HOUR_QUO: begin
                cmd.op     = es2cd_pkg::OP_HOUR_QUO;
                state_next = ST_HOUR_REM;
            end
            ST_HOUR_REM: begin
                cmd.op     = es2cd_pkg::OP_HOUR_REM;
                state_next = ST_MIN_QUO;
            end
            ST_MIN_QUO: begin
                cmd.op     = es2cd_pkg::OP_MIN_QUO;
                state_next = ST_MIN_REM;
            end
            ST_MIN_REM: begin
                cmd.op     = es2cd_pkg::OP_MIN_REM;
                state_next = ST_WDAY_QUO;
            end
            ST_WDAY_QUO: begin
                cmd.op     = es2cd_pkg::OP_WDAY_QUO;
                state_next = ST_WDAY_REM;
            end
            ST_WDAY_REM: begin
                cmd.op     = es2cd_pkg::OP_WDAY_REM;
                state_next = ST_YEAR;
            end
            ST_YEAR: begin
                if (status.year_fits) begin
                    cmd.op = es2cd_pkg::OP_YEAR_STEP;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (status.month_fits) begin
                    cmd.op = es2cd_pkg::OP_MONTH_STEP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = es2cd_pkg::OP_FINISH;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/epoch_seconds_to_calendar_date.sv
// top level: unix seconds to utc date, weekday and time of day
`default_nettype none

// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// input    | s_valid / s_ready  | s_epoch_seconds (31 bits)
// result   | m_valid / m_ready  | m_day_of_month, m_month_number, m_year_number,
//          |                    | m_weekday, m_hour_of_day, m_minute_of_hour,
//          |                    | m_second_of_minute
//
// one request at a time; after accept the engine runs eight fixed multiply steps,
// then the year walk (one year per cycle) from 1970 and the month walk through the
// year, and only then raises m_valid
// a new request is taken as soon as the engine is idle, even if a result waits
// reset (aresetn, synchronous, active low) clears only the control state
// a stalled result holds its registers; the engine waits before overwriting them

module epoch_seconds_to_calendar_date (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [es2cd_pkg::TIME_W-1:0]  s_epoch_seconds,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [4:0]                   m_day_of_month,
    output logic [3:0]                   m_month_number,
    output logic [es2cd_pkg::YEAR_W-1:0] m_year_number,
    output logic [2:0]                   m_weekday,
    output logic [4:0]                   m_hour_of_day,
    output logic [5:0]                   m_minute_of_hour,
    output logic [5:0]                   m_second_of_minute
);

    // command from controller to datapath, status back
    es2cd_pkg::cmd_t    cmd;
    es2cd_pkg::status_t status;

    // sequencer: split off day, hour, minute, week, then walk years and months
    es2cd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // reciprocal multiplier, leap tracking and result registers
    es2cd_dpath u_dpath (
        .aclk               (aclk),
        .cmd                (cmd),
        .status             (status),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_day_of_month     (m_day_of_month),
        .m_month_number     (m_month_number),
        .m_year_number      (m_year_number),
        .m_weekday          (m_weekday),
        .m_hour_of_day      (m_hour_of_day),
        .m_minute_of_hour   (m_minute_of_hour),
        .m_second_of_minute (m_second_of_minute)
    );

endmodule

`default_nettype wire
